### src/sof_crc_frame_deframer_core_defines.svh
// assertion macros for the deframer core
`ifndef SOF_CRC_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define SOF_CRC_FRAME_DEFRAMER_CORE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define SOFDF_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define SOFDF_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### src/sofdf_pkg.sv
package sofdf_pkg;

    // byte store geometry
    localparam int STORE_BYTES = 32;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int FILL_W      = AW + 1;
    localparam int OFF_W       = FILL_W + 1;

    // frame layout
    localparam int HDR_BYTES   = 9;
    localparam int LEN_OFFSET  = 7;
    localparam int WORD_OFFSET = 5;
    localparam int CRC_SKIP    = 2;
    localparam int A_OFFSET    = 2;
    localparam int B_OFFSET    = 3;
    localparam int CRC_BYTES   = 2;

    // register reset values
    localparam logic [7:0]  MARKER_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  MARKER_SECOND_RST = 8'h55;
    localparam logic [4:0]  MAX_PAYLOAD_RST   = 5'd21;
    localparam logic [15:0] CRC_SEED_RST      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'h1021;

    typedef enum logic [1:0] {
        REG_MARKER_FIRST  = 2'd0,
        REG_MARKER_SECOND = 2'd1,
        REG_MAX_PAYLOAD   = 2'd2,
        REG_CRC_SEED      = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        EV_HEADER   = 2'd0,
        EV_PAYLOAD  = 2'd1,
        EV_CRC_FAIL = 2'd2
    } event_kind_t;

    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [15:0] word;
        logic [4:0]  count;
        logic [7:0]  pbyte;
        logic        frame_end;
    } result_t;

    // one byte of crc-16 ccitt, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### src/sofdf_ram.sv
module sofdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### src/sof_crc_frame_deframer_core.sv
// Start-of-frame deframer with length field and CRC-16 check. Each byte taken on the
// s_ side goes into a 32-byte circular store (oldest byte dropped when full); the block
// then rescans the store: it skips to the start marker, reads the little-endian length
// at offset 7, and checks the CRC-16 (0x1021, MSB first, seed from crc_seed) over bytes
// 2 up to the two CRC bytes. A good frame gives a header transaction and one transaction
// per payload byte; a CRC failure gives one failure transaction. m_tlast marks the last
// transaction caused by one input byte. One byte is handled at a time: the store is a
// single-port-read RAM streamed one byte per cycle during the scan, header and CRC
// passes; payload bytes are read one at a time as each is emitted, and stall while
// m_tready is low.
// Registers are written over APB at byte addresses 0, 4, 8 and 12.
module sof_crc_frame_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [7:0] header_byte_a, [15:8] header_byte_b,
                                    // [31:16] header_word, [36:32] payload_count,
                                    // [44:37] payload_byte, [45] frame_end, [47:46] zero
    output logic [1:0]  m_tuser,    // [1:0] event_kind
    output logic        m_tlast,    // run_last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "sof_crc_frame_deframer_core_defines.svh"

    localparam int AW     = sofdf_pkg::AW;
    localparam int FILL_W = sofdf_pkg::FILL_W;
    localparam int OFF_W  = sofdf_pkg::OFF_W;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SCAN    = 7'b0000010,
        ST_HDR     = 7'b0000100,
        ST_CRC     = 7'b0001000,
        ST_VERDICT = 7'b0010000,
        ST_PAY     = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  marker_first_reg, marker_second_reg;
    logic [4:0]  max_payload_reg;
    logic [15:0] crc_seed_reg;

    logic [AW-1:0]     head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [OFF_W-1:0]  ioff_reg, ioff_next;
    logic [OFF_W-1:0]  doff_reg, doff_next;
    logic              dv_reg, dv_next;
    logic [7:0]        prev_reg, prev_next;
    logic [7:0]        hdr_a_reg, hdr_a_next;
    logic [7:0]        hdr_b_reg, hdr_b_next;
    logic [15:0]       word_reg, word_next;
    logic [7:0]        len_lo_reg, len_lo_next;
    logic [4:0]        plen_reg, plen_next;
    logic [OFF_W-1:0]  flen_reg, flen_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        want_lo_reg, want_lo_next;
    logic              match_reg, match_next;

    logic                 pend_valid_reg, pend_valid_next;
    sofdf_pkg::result_t   pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    sofdf_pkg::result_t   out_reg, out_next;
    logic                 out_last_reg, out_last_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    logic cfg_write;
    logic in_accept;

    // byte store
    sofdf_ram #(
        .WIDTH(8),
        .DEPTH(sofdf_pkg::STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_first_reg  <= sofdf_pkg::MARKER_FIRST_RST;
            marker_second_reg <= sofdf_pkg::MARKER_SECOND_RST;
            max_payload_reg   <= sofdf_pkg::MAX_PAYLOAD_RST;
            crc_seed_reg      <= sofdf_pkg::CRC_SEED_RST;
        end
        else if (cfg_write)
        begin
            case (sofdf_pkg::reg_index_t'(paddr[3:2]))
                sofdf_pkg::REG_MARKER_FIRST:  marker_first_reg  <= pwdata[7:0];
                sofdf_pkg::REG_MARKER_SECOND: marker_second_reg <= pwdata[7:0];
                sofdf_pkg::REG_MAX_PAYLOAD:   max_payload_reg   <= pwdata[4:0];
                sofdf_pkg::REG_CRC_SEED:      crc_seed_reg      <= pwdata[15:0];
                default:                      ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (sofdf_pkg::reg_index_t'(paddr[3:2]))
            sofdf_pkg::REG_MARKER_FIRST:  prdata = {24'd0, marker_first_reg};
            sofdf_pkg::REG_MARKER_SECOND: prdata = {24'd0, marker_second_reg};
            sofdf_pkg::REG_MAX_PAYLOAD:   prdata = {27'd0, max_payload_reg};
            sofdf_pkg::REG_CRC_SEED:      prdata = {16'd0, crc_seed_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // store access
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign ram_we    = in_accept;
    assign ram_waddr = head_reg + fill_reg[AW-1:0];
    assign ram_raddr = head_reg + ioff_reg[AW-1:0];

    // rescan sequencer
    always_comb
    begin
        logic                 out_free;
        logic                 can_emit;
        logic                 scan_done;
        logic [FILL_W-1:0]    start;
        logic [FILL_W-1:0]    left;
        logic [15:0]          plen_full;
        logic [16:0]          flen_full;
        sofdf_pkg::result_t   res;
        logic                 do_emit;
        logic                 finish_push;

        state_next      = state_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        ioff_next       = ioff_reg;
        doff_next       = doff_reg;
        dv_next         = 1'b0;
        prev_next       = prev_reg;
        hdr_a_next      = hdr_a_reg;
        hdr_b_next      = hdr_b_reg;
        word_next       = word_reg;
        len_lo_next     = len_lo_reg;
        plen_next       = plen_reg;
        flen_next       = flen_reg;
        crc_next        = crc_reg;
        want_lo_next    = want_lo_reg;
        match_next      = match_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;

        out_free    = !out_valid_reg || m_tready;
        can_emit    = !pend_valid_reg || out_free;
        scan_done   = 1'b0;
        start       = '0;
        left        = '0;
        plen_full   = {ram_rdata, len_lo_reg};
        flen_full   = 17'(plen_full) + 17'(sofdf_pkg::HDR_BYTES + sofdf_pkg::CRC_BYTES);
        res         = '0;
        do_emit     = 1'b0;
        finish_push = 1'b0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (fill_reg == FILL_W'(sofdf_pkg::STORE_BYTES))
                        head_next = head_reg + AW'(1);
                    else
                        fill_next = fill_reg + FILL_W'(1);
                    ioff_next  = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (fill_reg < FILL_W'(2))
                    state_next = ST_FINISH;
                else
                begin
                    // look for the marker pair in the returning byte stream
                    if (dv_reg && doff_reg != '0 && prev_reg == marker_first_reg
                        && ram_rdata == marker_second_reg)
                    begin
                        scan_done = 1'b1;
                        start     = FILL_W'(doff_reg - OFF_W'(1));
                    end
                    else if (dv_reg && doff_reg == OFF_W'(fill_reg) - OFF_W'(1))
                    begin
                        scan_done = 1'b1;
                        start     = fill_reg - FILL_W'(1);
                    end

                    if (scan_done)
                    begin
                        left      = fill_reg - start;
                        head_next = head_reg + start[AW-1:0];
                        fill_next = left;
                        if (left < FILL_W'(sofdf_pkg::HDR_BYTES))
                            state_next = ST_FINISH;
                        else
                        begin
                            ioff_next  = OFF_W'(sofdf_pkg::A_OFFSET);
                            state_next = ST_HDR;
                        end
                    end
                    else
                    begin
                        if (dv_reg)
                            prev_next = ram_rdata;
                        if (ioff_reg < OFF_W'(fill_reg))
                        begin
                            dv_next   = 1'b1;
                            doff_next = ioff_reg;
                            ioff_next = ioff_reg + OFF_W'(1);
                        end
                    end
                end
            end

            ST_HDR:
            begin
                if (dv_reg && doff_reg == OFF_W'(sofdf_pkg::LEN_OFFSET + 1))
                begin
                    if (plen_full > 16'(max_payload_reg))
                    begin
                        head_next  = head_reg + AW'(1);
                        fill_next  = fill_reg - FILL_W'(1);
                        ioff_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else if (17'(fill_reg) < flen_full)
                        state_next = ST_FINISH;
                    else
                    begin
                        plen_next  = plen_full[4:0];
                        flen_next  = flen_full[OFF_W-1:0];
                        crc_next   = crc_seed_reg;
                        ioff_next  = OFF_W'(sofdf_pkg::CRC_SKIP);
                        state_next = ST_CRC;
                    end
                end
                else
                begin
                    // capture the header fields as they stream by
                    if (dv_reg)
                    begin
                        if (doff_reg == OFF_W'(sofdf_pkg::A_OFFSET))
                            hdr_a_next = ram_rdata;
                        if (doff_reg == OFF_W'(sofdf_pkg::B_OFFSET))
                            hdr_b_next = ram_rdata;
                        if (doff_reg == OFF_W'(sofdf_pkg::WORD_OFFSET))
                            word_next[7:0] = ram_rdata;
                        if (doff_reg == OFF_W'(sofdf_pkg::WORD_OFFSET + 1))
                            word_next[15:8] = ram_rdata;
                        if (doff_reg == OFF_W'(sofdf_pkg::LEN_OFFSET))
                            len_lo_next = ram_rdata;
                    end
                    if (ioff_reg < OFF_W'(sofdf_pkg::HDR_BYTES))
                    begin
                        dv_next   = 1'b1;
                        doff_next = ioff_reg;
                        ioff_next = ioff_reg + OFF_W'(1);
                    end
                end
            end

            ST_CRC:
            begin
                if (dv_reg && doff_reg == flen_reg - OFF_W'(1))
                begin
                    match_next = ({ram_rdata, want_lo_reg} == crc_reg);
                    state_next = ST_VERDICT;
                end
                else
                begin
                    // crc over the body, then pick up the stored crc
                    if (dv_reg)
                    begin
                        if (doff_reg < flen_reg - OFF_W'(sofdf_pkg::CRC_BYTES))
                            crc_next = sofdf_pkg::crc_byte(crc_reg, ram_rdata);
                        else
                            want_lo_next = ram_rdata;
                    end
                    if (ioff_reg < flen_reg)
                    begin
                        dv_next   = 1'b1;
                        doff_next = ioff_reg;
                        ioff_next = ioff_reg + OFF_W'(1);
                    end
                end
            end

            ST_VERDICT:
            begin
                if (can_emit)
                begin
                    do_emit = 1'b1;
                    if (match_reg)
                    begin
                        res.kind      = sofdf_pkg::EV_HEADER;
                        res.byte_a    = hdr_a_reg;
                        res.byte_b    = hdr_b_reg;
                        res.word      = word_reg;
                        res.count     = plen_reg;
                        res.frame_end = (plen_reg == 5'd0);
                        if (plen_reg == 5'd0)
                        begin
                            head_next  = head_reg + flen_reg[AW-1:0];
                            fill_next  = fill_reg - flen_reg[FILL_W-1:0];
                            ioff_next  = '0;
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            ioff_next  = OFF_W'(sofdf_pkg::HDR_BYTES);
                            state_next = ST_PAY;
                        end
                    end
                    else
                    begin
                        res.kind   = sofdf_pkg::EV_CRC_FAIL;
                        head_next  = head_reg + AW'(1);
                        fill_next  = fill_reg - FILL_W'(1);
                        ioff_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_PAY:
            begin
                // read address holds on ioff, data is good in the cycle after
                if (!dv_reg)
                    dv_next = 1'b1;
                else if (can_emit)
                begin
                    do_emit       = 1'b1;
                    res.kind      = sofdf_pkg::EV_PAYLOAD;
                    res.pbyte     = ram_rdata;
                    res.frame_end = (ioff_reg == flen_reg - OFF_W'(sofdf_pkg::CRC_BYTES + 1));
                    if (res.frame_end)
                    begin
                        head_next  = head_reg + flen_reg[AW-1:0];
                        fill_next  = fill_reg - flen_reg[FILL_W-1:0];
                        ioff_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else
                        ioff_next = ioff_reg + OFF_W'(1);
                end
                else
                    dv_next = 1'b1;
            end

            ST_FINISH:
            begin
                if (!pend_valid_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    finish_push     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // one result is held back until it is known whether it is the last
        if (do_emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_next       = res;
            pend_valid_next = 1'b1;
        end
        if (finish_push)
        begin
            out_valid_next = 1'b1;
            out_next       = pend_reg;
            out_last_next  = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            dv_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            dv_reg         <= dv_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ioff_reg     <= ioff_next;
        doff_reg     <= doff_next;
        prev_reg     <= prev_next;
        hdr_a_reg    <= hdr_a_next;
        hdr_b_reg    <= hdr_b_next;
        word_reg     <= word_next;
        len_lo_reg   <= len_lo_next;
        plen_reg     <= plen_next;
        flen_reg     <= flen_next;
        crc_reg      <= crc_next;
        want_lo_reg  <= want_lo_next;
        match_reg    <= match_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // result port
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_reg.frame_end, out_reg.pbyte, out_reg.count,
                       out_reg.word, out_reg.byte_b, out_reg.byte_a};

    // checks
    `SOFDF_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1,
        fill_reg <= FILL_W'(sofdf_pkg::STORE_BYTES), "fill level above store size")
    `SOFDF_ASSERT_NEXT(a_accept_scan, clk, rst_n, in_accept,
        state_reg == ST_SCAN, "accepted byte did not start a rescan")
    `SOFDF_ASSERT_SAME(a_idle_drained, clk, rst_n, state_reg == ST_IDLE,
        !pend_valid_reg, "held result left behind at idle")
    `SOFDF_ASSERT_SAME(a_fail_no_end, clk, rst_n,
        out_valid_reg && out_reg.kind == sofdf_pkg::EV_CRC_FAIL,
        !out_reg.frame_end, "frame end set on crc failure")

endmodule
